/* sv/gbts_pkg.sv */
// Shared types, constants, microcode and dispatch table of the gap buffer text store.
package gbts_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 13;
    localparam int UPC_W    = 5;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        REQ_INS_B   = 4'd0,
        REQ_INS_A   = 4'd1,
        REQ_BKSP    = 4'd2,
        REQ_DEL     = 4'd3,
        REQ_LEFT    = 4'd4,
        REQ_RIGHT   = 4'd5,
        REQ_MOVE_TO = 4'd6,
        REQ_START   = 4'd7,
        REQ_END     = 4'd8,
        REQ_READ    = 4'd9
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } stat_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INS_B,
        OP_INS_A,
        OP_DEL_B,
        OP_DEL_A,
        OP_SETUP,
        OP_PRIME_L,
        OP_PRIME_R,
        OP_SHIFT_L,
        OP_SHIFT_R,
        OP_RD_IDX,
        OP_RD_CAP,
        OP_RD_BB,
        OP_RD_BA,
        OP_FIN
    } uop_t;

    typedef enum logic [1:0] {
        C_NEVER,
        C_REM_ZERO,
        C_DIR_R,
        C_REM_MORE
    } cond_t;

    typedef struct packed {
        uop_t             op;
        cond_t            cond;
        logic [UPC_W-1:0] br;
        logic [UPC_W-1:0] nx;
        logic             last;
    } uword_t;

    typedef struct packed {
        logic accept;
        uop_t op;
    } ctrl_t;

    typedef struct packed {
        logic rem_zero;
        logic rem_more;
        logic dir_r;
    } flags_t;

    // Microcode addresses.
    localparam logic [UPC_W-1:0] UA_INS_B    = 5'd0;
    localparam logic [UPC_W-1:0] UA_INS_A    = 5'd1;
    localparam logic [UPC_W-1:0] UA_DEL_B    = 5'd2;
    localparam logic [UPC_W-1:0] UA_DEL_A    = 5'd3;
    localparam logic [UPC_W-1:0] UA_NOP      = 5'd4;
    localparam logic [UPC_W-1:0] UA_READ     = 5'd5;
    localparam logic [UPC_W-1:0] UA_READ_CAP = 5'd6;
    localparam logic [UPC_W-1:0] UA_SETUP    = 5'd7;
    localparam logic [UPC_W-1:0] UA_CHK      = 5'd8;
    localparam logic [UPC_W-1:0] UA_DIR      = 5'd9;
    localparam logic [UPC_W-1:0] UA_PRIME_L  = 5'd10;
    localparam logic [UPC_W-1:0] UA_SHIFT_L  = 5'd11;
    localparam logic [UPC_W-1:0] UA_PRIME_R  = 5'd12;
    localparam logic [UPC_W-1:0] UA_SHIFT_R  = 5'd13;
    localparam logic [UPC_W-1:0] UA_FIN_A    = 5'd14;
    localparam logic [UPC_W-1:0] UA_FIN_B    = 5'd15;
    localparam logic [UPC_W-1:0] UA_FIN_C    = 5'd16;

    function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
        uword_t w;
        w = '{op: OP_NONE, cond: C_NEVER, br: UA_FIN_A, nx: UA_FIN_A, last: 1'b0};
        unique case (upc)
            UA_INS_B:    w.op = OP_INS_B;
            UA_INS_A:    w.op = OP_INS_A;
            UA_DEL_B:    w.op = OP_DEL_B;
            UA_DEL_A:    w.op = OP_DEL_A;
            UA_NOP:      w.op = OP_NONE;
            UA_READ:
            begin
                w.op = OP_RD_IDX;
                w.nx = UA_READ_CAP;
            end
            UA_READ_CAP: w.op = OP_RD_CAP;
            UA_SETUP:
            begin
                w.op = OP_SETUP;
                w.nx = UA_CHK;
            end
            UA_CHK:
            begin
                w.cond = C_REM_ZERO;
                w.br   = UA_FIN_A;
                w.nx   = UA_DIR;
            end
            UA_DIR:
            begin
                w.cond = C_DIR_R;
                w.br   = UA_PRIME_R;
                w.nx   = UA_PRIME_L;
            end
            UA_PRIME_L:
            begin
                w.op = OP_PRIME_L;
                w.nx = UA_SHIFT_L;
            end
            UA_SHIFT_L:
            begin
                w.op   = OP_SHIFT_L;
                w.cond = C_REM_MORE;
                w.br   = UA_SHIFT_L;
            end
            UA_PRIME_R:
            begin
                w.op = OP_PRIME_R;
                w.nx = UA_SHIFT_R;
            end
            UA_SHIFT_R:
            begin
                w.op   = OP_SHIFT_R;
                w.cond = C_REM_MORE;
                w.br   = UA_SHIFT_R;
            end
            UA_FIN_A:
            begin
                w.op = OP_RD_BB;
                w.nx = UA_FIN_B;
            end
            UA_FIN_B:
            begin
                w.op = OP_RD_BA;
                w.nx = UA_FIN_C;
            end
            UA_FIN_C:
            begin
                w.op   = OP_FIN;
                w.last = 1'b1;
            end
            default:
            begin
                w.op   = OP_NONE;
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] entry_of(input logic [3:0] rt);
        logic [UPC_W-1:0] a;
        unique case (rt) inside
            REQ_INS_B: a = UA_INS_B;
            REQ_INS_A: a = UA_INS_A;
            REQ_BKSP:  a = UA_DEL_B;
            REQ_DEL:   a = UA_DEL_A;
            REQ_LEFT, REQ_RIGHT, REQ_MOVE_TO, REQ_START, REQ_END: a = UA_SETUP;
            REQ_READ:  a = UA_READ;
            default:   a = UA_NOP;
        endcase
        return a;
    endfunction

endpackage

/* sv/gap_buffer_text_store_core.sv */
// Gap buffer text store: one byte memory split at the cursor, driven by a microprogram.
//
// A request is taken when start is high and busy is low; its one result appears on the
// output ports for a single cycle with done high and must be taken then, as there is no
// way to hold it. Inserts, removals and unused request codes run their operation step, reads
// an index step and a capture step, and cursor moves a setup step, a check that skips ahead
// when nothing moves, a direction step, a prime step and the byte copy across the gap.
// The copy runs at one byte per cycle, set by the single write port of the text memory, and
// the last three steps of every request read the bytes on either side of the cursor through
// its single read port. A new request may be started in the cycle that shows done.
module gap_buffer_text_store_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [3:0]                 req_type,
    input  logic [7:0]                 char_in,
    input  logic [gbts_pkg::CNT_W-1:0] count_or_index,
    output logic                       done,
    output logic [gbts_pkg::CNT_W-1:0] moved_count,
    output logic [7:0]                 read_byte,
    output logic [7:0]                 byte_before_cursor,
    output logic [7:0]                 byte_after_cursor,
    output logic [gbts_pkg::CNT_W-1:0] before_length,
    output logic [gbts_pkg::CNT_W-1:0] after_length,
    output logic [1:0]                 status
);
    import gbts_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    gbts_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .flags    (flags),
        .ctrl     (ctrl),
        .busy     (busy),
        .done     (done)
    );

    gbts_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .req_type           (req_type),
        .char_in            (char_in),
        .count_or_index     (count_or_index),
        .flags              (flags),
        .moved_count        (moved_count),
        .read_byte          (read_byte),
        .byte_before_cursor (byte_before_cursor),
        .byte_after_cursor  (byte_after_cursor),
        .before_length      (before_length),
        .after_length       (after_length),
        .status             (status)
    );

endmodule

/* sv/gbts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/gbts_useq.sv */
// Microprogram sequencer: step counter, control store and branch logic.
module gbts_useq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [3:0]            req_type,
    input  gbts_pkg::flags_t      flags,
    output gbts_pkg::ctrl_t       ctrl,
    output logic                  busy,
    output logic                  done
);
    import gbts_pkg::*;

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             accept;
    logic             taken;
    uword_t           word;

    assign accept = start && !busy_reg;
    assign word   = ucode(upc_reg);

    always_comb
    begin
        case (word.cond)
            C_REM_ZERO: taken = flags.rem_zero;
            C_DIR_R:    taken = flags.dir_r;
            C_REM_MORE: taken = flags.rem_more;
            default:    taken = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next  = upc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (accept)
        begin
            upc_next  = entry_of(req_type);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            upc_next = taken ? word.br : word.nx;
            if (word.last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign ctrl.accept = accept;
    assign ctrl.op     = busy_reg ? word.op : OP_NONE;
    assign busy        = busy_reg;
    assign done        = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while a request is still running");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted request did not start the sequencer");

endmodule

/* sv/gbts_dpath.sv */
// Datapath: cursor counts, move counter, memory addressing and result registers.
module gbts_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbts_pkg::ctrl_t               ctrl,
    input  logic [3:0]                    req_type,
    input  logic [7:0]                    char_in,
    input  logic [gbts_pkg::CNT_W-1:0]    count_or_index,
    output gbts_pkg::flags_t              flags,
    output logic [gbts_pkg::CNT_W-1:0]    moved_count,
    output logic [7:0]                    read_byte,
    output logic [7:0]                    byte_before_cursor,
    output logic [7:0]                    byte_after_cursor,
    output logic [gbts_pkg::CNT_W-1:0]    before_length,
    output logic [gbts_pkg::CNT_W-1:0]    after_length,
    output logic [1:0]                    status
);
    import gbts_pkg::*;

    logic [CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [CNT_W-1:0]  acnt_reg, acnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              dir_r_reg, dir_r_next;
    logic [CNT_W-1:0]  moved_reg, moved_next;
    logic [7:0]        rd_reg, rd_next;
    logic [7:0]        bb_reg, bb_next;
    logic [7:0]        ba_reg, ba_next;
    stat_t             status_reg, status_next;
    logic [3:0]        type_reg;
    logic [7:0]        ch_reg;
    logic [CNT_W-1:0]  arg_reg;

    logic [CNT_W:0]    total;
    logic              full;
    logic [CNT_W-1:0]  fwd_dist;
    logic [CNT_W:0]    idx_far;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;

    assign total    = {1'b0, bcnt_reg} + {1'b0, acnt_reg};
    assign full     = total >= (CNT_W+1)'(CAPACITY);
    assign fwd_dist = arg_reg - bcnt_reg;
    // Logical index past the cursor maps into the top part, beyond the gap.
    assign idx_far  = {1'b0, arg_reg} + {1'b0, CAP_CNT} - total;

    always_comb
    begin
        bcnt_next   = bcnt_reg;
        acnt_next   = acnt_reg;
        rem_next    = rem_reg;
        dir_r_next  = dir_r_reg;
        moved_next  = moved_reg;
        rd_next     = rd_reg;
        bb_next     = bb_reg;
        ba_next     = ba_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = bcnt_reg[ADDR_W-1:0];
        wdata       = ch_reg;
        raddr       = ADDR_W'(bcnt_reg - CNT_W'(1));

        if (ctrl.accept)
        begin
            moved_next  = '0;
            rd_next     = '0;
            status_next = ST_OK;
        end

        unique case (ctrl.op)
            OP_NONE: ;
            OP_INS_B:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    we        = 1'b1;
                    bcnt_next = bcnt_reg + CNT_W'(1);
                end
            end
            OP_INS_A:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = ADDR_W'(CAP_CNT - acnt_reg - CNT_W'(1));
                    acnt_next = acnt_reg + CNT_W'(1);
                end
            end
            OP_DEL_B:
            begin
                if (bcnt_reg == '0)
                    status_next = ST_EMPTY;
                else
                    bcnt_next = bcnt_reg - CNT_W'(1);
            end
            OP_DEL_A:
            begin
                if (acnt_reg == '0)
                    status_next = ST_EMPTY;
                else
                    acnt_next = acnt_reg - CNT_W'(1);
            end
            OP_SETUP:
            begin
                case (type_reg)
                    REQ_LEFT:
                    begin
                        rem_next   = (arg_reg < bcnt_reg) ? arg_reg : bcnt_reg;
                        dir_r_next = 1'b0;
                    end
                    REQ_RIGHT:
                    begin
                        rem_next   = (arg_reg < acnt_reg) ? arg_reg : acnt_reg;
                        dir_r_next = 1'b1;
                    end
                    REQ_MOVE_TO:
                    begin
                        if (arg_reg >= bcnt_reg)
                        begin
                            rem_next   = (fwd_dist < acnt_reg) ? fwd_dist : acnt_reg;
                            dir_r_next = 1'b1;
                        end
                        else
                        begin
                            rem_next   = bcnt_reg - arg_reg;
                            dir_r_next = 1'b0;
                        end
                    end
                    REQ_START:
                    begin
                        rem_next   = bcnt_reg;
                        dir_r_next = 1'b0;
                    end
                    REQ_END:
                    begin
                        rem_next   = acnt_reg;
                        dir_r_next = 1'b1;
                    end
                    default:
                    begin
                        rem_next   = '0;
                        dir_r_next = 1'b0;
                    end
                endcase
                moved_next = rem_next;
            end
            OP_PRIME_L: raddr = ADDR_W'(bcnt_reg - CNT_W'(1));
            OP_PRIME_R: raddr = ADDR_W'(CAP_CNT - acnt_reg);
            OP_SHIFT_L:
            begin
                // Write the byte fetched last cycle and fetch the next one ahead.
                we        = 1'b1;
                waddr     = ADDR_W'(CAP_CNT - acnt_reg - CNT_W'(1));
                wdata     = rdata;
                bcnt_next = bcnt_reg - CNT_W'(1);
                acnt_next = acnt_reg + CNT_W'(1);
                rem_next  = rem_reg - CNT_W'(1);
                raddr     = ADDR_W'(bcnt_reg - CNT_W'(2));
            end
            OP_SHIFT_R:
            begin
                we        = 1'b1;
                waddr     = bcnt_reg[ADDR_W-1:0];
                wdata     = rdata;
                bcnt_next = bcnt_reg + CNT_W'(1);
                acnt_next = acnt_reg - CNT_W'(1);
                rem_next  = rem_reg - CNT_W'(1);
                raddr     = ADDR_W'(CAP_CNT - acnt_reg + CNT_W'(1));
            end
            OP_RD_IDX:
            begin
                if ({1'b0, arg_reg} >= total)
                    status_next = ST_RANGE;
                if (arg_reg < bcnt_reg)
                    raddr = arg_reg[ADDR_W-1:0];
                else
                    raddr = idx_far[ADDR_W-1:0];
            end
            OP_RD_CAP:
            begin
                if (status_reg == ST_OK)
                    rd_next = rdata;
            end
            OP_RD_BB: raddr = ADDR_W'(bcnt_reg - CNT_W'(1));
            OP_RD_BA:
            begin
                bb_next = (bcnt_reg != '0) ? rdata : 8'd0;
                raddr   = ADDR_W'(CAP_CNT - acnt_reg);
            end
            OP_FIN: ba_next = (acnt_reg != '0) ? rdata : 8'd0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg <= '0;
            acnt_reg <= '0;
        end
        else
        begin
            bcnt_reg <= bcnt_next;
            acnt_reg <= acnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        dir_r_reg  <= dir_r_next;
        moved_reg  <= moved_next;
        rd_reg     <= rd_next;
        bb_reg     <= bb_next;
        ba_reg     <= ba_next;
        status_reg <= status_next;
        if (ctrl.accept)
        begin
            type_reg <= req_type;
            ch_reg   <= char_in;
            arg_reg  <= count_or_index;
        end
    end

    gbts_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign flags.rem_zero   = (rem_reg == '0);
    assign flags.rem_more   = (rem_reg != CNT_W'(1));
    assign flags.dir_r      = dir_r_reg;

    assign moved_count        = moved_reg;
    assign read_byte          = rd_reg;
    assign byte_before_cursor = bb_reg;
    assign byte_after_cursor  = ba_reg;
    assign before_length      = bcnt_reg;
    assign after_length       = acnt_reg;
    assign status             = status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= (CNT_W+1)'(CAPACITY))
        else $error("text length exceeds the memory size");

    a_shift_l_src: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_SHIFT_L) |-> (rem_reg != '0 && bcnt_reg != '0))
        else $error("left shift with nothing left to move");

    a_shift_r_src: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_SHIFT_R) |-> (rem_reg != '0 && acnt_reg != '0))
        else $error("right shift with nothing left to move");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the gap buffer text store core, with its own gap buffer predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gbts_pkg::*;

    localparam logic [3:0] REQ_UNUSED_LO = 4'd10;
    localparam logic [3:0] REQ_UNUSED_HI = 4'd15;
    localparam int ARG_MAX        = (1 << CNT_W) - 1;
    localparam int RANDOM_ITEMS   = 1640;
    localparam int CYCLE_LIMIT    = 5_000_000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [CNT_W-1:0] moved;
        logic [7:0]       rd;
        logic [7:0]       bb;
        logic [7:0]       ba;
        logic [CNT_W-1:0] blen;
        logic [CNT_W-1:0] alen;
        stat_t            stat;
    } text_result_t;

    typedef struct {
        logic [3:0]       req;
        logic [7:0]       ch;
        logic [CNT_W-1:0] arg;
        logic             typed;
        text_result_t     want;
    } script_row_t;

    localparam text_result_t NO_WANT = '0;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [3:0]       req_type;
    logic [7:0]       char_in;
    logic [CNT_W-1:0] count_or_index;
    logic             done;
    logic [CNT_W-1:0] moved_count;
    logic [7:0]       read_byte;
    logic [7:0]       byte_before_cursor;
    logic [7:0]       byte_after_cursor;
    logic [CNT_W-1:0] before_length;
    logic [CNT_W-1:0] after_length;
    logic [1:0]       status;

    // Predicted image of the text: before part at the bottom, after part at the top.
    logic [7:0]   text_img [0:CAPACITY-1];
    int           pre_len = 0;
    int           post_len = 0;
    text_result_t pending_results [$];
    script_row_t  script [$];
    int           errors = 0;
    int           cycles = 0;
    bit           steady = 1'b0;

    gap_buffer_text_store_core DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .req_type           (req_type),
        .char_in            (char_in),
        .count_or_index     (count_or_index),
        .done               (done),
        .moved_count        (moved_count),
        .read_byte          (read_byte),
        .byte_before_cursor (byte_before_cursor),
        .byte_after_cursor  (byte_after_cursor),
        .before_length      (before_length),
        .after_length       (after_length),
        .status             (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void add_row(input script_row_t row);
        script.insert(script.size(), row);
    endfunction

    function automatic int cross_left(input int n);
        int m;
        m = (n < pre_len) ? n : pre_len;
        for (int k = 0; k < m; k++)
        begin
            pre_len--;
            post_len++;
            text_img[CAPACITY - post_len] = text_img[pre_len];
        end
        return m;
    endfunction

    function automatic int cross_right(input int n);
        int m;
        m = (n < post_len) ? n : post_len;
        for (int k = 0; k < m; k++)
        begin
            text_img[pre_len] = text_img[CAPACITY - post_len];
            pre_len++;
            post_len--;
        end
        return m;
    endfunction

    function automatic text_result_t apply_request(input logic [3:0] req, input logic [7:0] ch,
                                                   input logic [CNT_W-1:0] arg);
        text_result_t r;
        int           total;
        int           idx;
        int           m;
        r     = '0;
        total = pre_len + post_len;
        idx   = int'(arg);
        m     = 0;
        case (req)
            REQ_INS_B:
                if (total >= CAPACITY)
                    r.stat = ST_FULL;
                else
                begin
                    text_img[pre_len] = ch;
                    pre_len++;
                end
            REQ_INS_A:
                if (total >= CAPACITY)
                    r.stat = ST_FULL;
                else
                begin
                    post_len++;
                    text_img[CAPACITY - post_len] = ch;
                end
            REQ_BKSP:
                if (pre_len == 0)
                    r.stat = ST_EMPTY;
                else
                    pre_len--;
            REQ_DEL:
                if (post_len == 0)
                    r.stat = ST_EMPTY;
                else
                    post_len--;
            REQ_LEFT:    m = cross_left(idx);
            REQ_RIGHT:   m = cross_right(idx);
            REQ_MOVE_TO:
                if (idx >= pre_len)
                    m = cross_right(idx - pre_len);
                else
                    m = cross_left(pre_len - idx);
            REQ_START:   m = cross_left(pre_len);
            REQ_END:     m = cross_right(post_len);
            REQ_READ:
                if (idx >= total)
                    r.stat = ST_RANGE;
                else if (idx < pre_len)
                    r.rd = text_img[idx];
                else
                    r.rd = text_img[CAPACITY - post_len + (idx - pre_len)];
            default: ;
        endcase
        r.moved = CNT_W'(m);
        r.bb    = (pre_len > 0) ? text_img[pre_len - 1] : 8'h00;
        r.ba    = (post_len > 0) ? text_img[CAPACITY - post_len] : 8'h00;
        r.blen  = CNT_W'(pre_len);
        r.alen  = CNT_W'(post_len);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one, and stretches with none at all.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(39, 0) == 0)
            steady = !steady;
        if (steady)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(3, 1);
        if (r < 96)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    task automatic issue(input logic [3:0] req, input logic [7:0] ch,
                         input logic [CNT_W-1:0] arg, input logic typed,
                         input text_result_t want);
        int           gap;
        text_result_t predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start          <= 1'b1;
        req_type       <= req;
        char_in        <= ch;
        count_or_index <= arg;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_request(req, ch, arg);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic issue_plain(input logic [3:0] req, input logic [7:0] ch,
                               input logic [CNT_W-1:0] arg);
        issue(req, ch, arg, 1'b0, NO_WANT);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return CNT_W'($urandom_range(4, 0));
        if (r < 88)
            return CNT_W'($urandom_range(pre_len + post_len + 2, 0));
        return CNT_W'($urandom_range(ARG_MAX, 0));
    endfunction

    function automatic logic [CNT_W-1:0] pick_read_index();
        int total;
        int r;
        total = pre_len + post_len;
        r     = $urandom_range(99, 0);
        if (total > 0 && r < 80)
            return CNT_W'($urandom_range(total - 1, 0));
        if (r < 95)
            return CNT_W'(total + $urandom_range(3, 0));
        return CNT_W'($urandom_range(ARG_MAX, 0));
    endfunction

    // One random request, steered so that the text length drifts towards the target.
    task automatic random_item(input int target);
        int               r;
        int               ins_limit;
        logic [3:0]       req;
        logic [CNT_W-1:0] arg;
        r         = $urandom_range(99, 0);
        ins_limit = (pre_len + post_len < target) ? 45 : 15;
        arg       = CNT_W'($urandom_range(ARG_MAX, 0));
        if (r < ins_limit)
            req = $urandom_range(1, 0) ? REQ_INS_A : REQ_INS_B;
        else if (r < 55)
            req = $urandom_range(1, 0) ? REQ_DEL : REQ_BKSP;
        else if (r < 67)
        begin
            req = $urandom_range(1, 0) ? REQ_RIGHT : REQ_LEFT;
            arg = pick_count();
        end
        else if (r < 74)
        begin
            req = REQ_MOVE_TO;
            arg = pick_count();
        end
        else if (r < 77)
            req = $urandom_range(1, 0) ? REQ_END : REQ_START;
        else if (r < 97)
        begin
            req = REQ_READ;
            arg = pick_read_index();
        end
        else
            req = 4'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
        issue_plain(req, 8'($urandom_range(255, 0)), arg);
    endtask

    // Each result is on the ports for one cycle only and is taken at the edge that ends it.
    always @(posedge clk)
    begin : result_check
        text_result_t got;
        text_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            got = '{moved_count, read_byte, byte_before_cursor, byte_after_cursor,
                    before_length, after_length, stat_t'(status)};
            if (pending_results.size() == 0)
            begin
                if (errors < REPORT_LIMIT)
                    $display("unexpected transaction: moved %0d rd %h bb %h ba %h len %0d/%0d st %0d",
                             got.moved, got.rd, got.bb, got.ba, got.blen, got.alen, got.stat);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.moved !== want.moved || got.rd !== want.rd || got.bb !== want.bb ||
                    got.ba !== want.ba || got.blen !== want.blen || got.alen !== want.alen ||
                    got.stat !== want.stat)
                begin
                    if (errors < REPORT_LIMIT)
                    begin
                        $display("mismatch exp: moved %0d rd %h bb %h ba %h len %0d/%0d st %0d",
                                 want.moved, want.rd, want.bb, want.ba, want.blen, want.alen,
                                 want.stat);
                        $display("         got: moved %0d rd %h bb %h ba %h len %0d/%0d st %0d",
                                 got.moved, got.rd, got.bb, got.ba, got.blen, got.alen,
                                 got.stat);
                    end
                    errors++;
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int target;
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_INS_B;
        char_in        = 8'h00;
        count_or_index = '0;

        // Empty text first, where every result can be written down directly.
        add_row('{REQ_READ, 8'h00, 13'd0, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_RANGE}});
        add_row('{REQ_BKSP, 8'h00, 13'd0, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_EMPTY}});
        add_row('{REQ_DEL, 8'hFF, 13'd8191, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_EMPTY}});
        add_row('{REQ_LEFT, 8'h00, 13'd8191, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_OK}});
        add_row('{REQ_RIGHT, 8'h00, 13'd4096, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_OK}});
        add_row('{REQ_MOVE_TO, 8'h00, 13'd4096, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_OK}});
        add_row('{REQ_START, 8'h00, 13'd0, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_OK}});
        add_row('{REQ_END, 8'h00, 13'd0, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_OK}});
        add_row('{REQ_UNUSED_HI, 8'hFF, 13'd8191, 1'b1,
                  '{13'd0, 8'h00, 8'h00, 8'h00, 13'd0, 13'd0, ST_OK}});
        add_row('{REQ_INS_B, 8'hFF, 13'd0, 1'b1,
                  '{13'd0, 8'h00, 8'hFF, 8'h00, 13'd1, 13'd0, ST_OK}});
        add_row('{REQ_INS_A, 8'h00, 13'd8191, 1'b1,
                  '{13'd0, 8'h00, 8'hFF, 8'h00, 13'd1, 13'd1, ST_OK}});
        add_row('{REQ_INS_A, 8'h5A, 13'd0, 1'b0, NO_WANT});
        add_row('{REQ_INS_B, 8'h80, 13'd0, 1'b0, NO_WANT});
        add_row('{REQ_READ, 8'h00, 13'd0, 1'b0, NO_WANT});
        add_row('{REQ_READ, 8'h00, 13'd3, 1'b0, NO_WANT});
        add_row('{REQ_READ, 8'h00, 13'd4, 1'b0, NO_WANT});
        add_row('{REQ_LEFT, 8'h00, 13'd1, 1'b0, NO_WANT});
        add_row('{REQ_RIGHT, 8'h00, 13'd8191, 1'b0, NO_WANT});
        add_row('{REQ_MOVE_TO, 8'h00, 13'd1, 1'b0, NO_WANT});
        add_row('{REQ_MOVE_TO, 8'h00, 13'd8191, 1'b0, NO_WANT});
        add_row('{REQ_START, 8'h00, 13'd0, 1'b0, NO_WANT});
        add_row('{REQ_UNUSED_LO, 8'h00, 13'd0, 1'b0, NO_WANT});
        add_row('{REQ_BKSP, 8'h00, 13'd0, 1'b0, NO_WANT});
        add_row('{REQ_DEL, 8'h00, 13'd0, 1'b0, NO_WANT});
        add_row('{REQ_END, 8'h00, 13'd0, 1'b0, NO_WANT});

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
            issue(script[i].req, script[i].ch, script[i].arg, script[i].typed, script[i].want);

        target = 8;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 120 == 0)
                target = ($urandom_range(9, 0) < 7) ? $urandom_range(40, 0)
                                                     : $urandom_range(300, 40);
            random_item(target);
        end

        // Let the block run dry before the long cursor moves.
        wait_for_results();
        issue_plain(REQ_INS_B, 8'hAA, 13'd0);
        issue_plain(REQ_INS_A, 8'h55, 13'd8191);
        issue_plain(REQ_READ, 8'h00, 13'd0);
        issue_plain(REQ_READ, 8'h00, 13'd4095);
        issue_plain(REQ_READ, 8'h00, 13'd4096);
        issue_plain(REQ_READ, 8'h00, 13'd8191);
        issue_plain(REQ_START, 8'h00, 13'd0);
        issue_plain(REQ_INS_B, 8'h01, 13'd0);
        issue_plain(REQ_READ, 8'h00, 13'd0);
        issue_plain(REQ_END, 8'h00, 13'd0);
        issue_plain(REQ_INS_A, 8'h02, 13'd0);
        issue_plain(REQ_MOVE_TO, 8'h00, 13'd2048);
        issue_plain(REQ_LEFT, 8'h00, 13'd8191);
        issue_plain(REQ_RIGHT, 8'h00, 13'd4096);
        issue_plain(REQ_MOVE_TO, 8'h00, 13'd8191);
        issue_plain(REQ_MOVE_TO, 8'h00, 13'd0);
        issue_plain(REQ_MOVE_TO, 8'h00, 13'd1500);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
sv/gbts_pkg.sv
sv/gbts_ram.sv
sv/gbts_useq.sv
sv/gbts_dpath.sv
sv/gap_buffer_text_store_core.sv
tb/testbench.sv
